[design/assert_macros.svh]
// assertion macros used by the design file dgcc_dp
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DGCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DGCC_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define DGCC_ASSERT(lbl, clk, rstn, prop, msg)
`define DGCC_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[design/dgcc_pkg.sv]
// types and constants of the cycle check
// no dependencies
package dgcc_pkg;
    localparam int NODE_W = 8;

    localparam logic [1:0] CLR_WHITE = 2'd0;
    localparam logic [1:0] CLR_GRAY  = 2'd1;
    localparam logic [1:0] CLR_BLACK = 2'd2;

    typedef struct packed {
        logic load;
        logic clr_start;
        logic clr_step;
        logic root_rd;
        logic root_take;
        logic root_next;
        logic scan_rd;
        logic col_rd;
        logic push;
        logic fail;
        logic pop_black;
        logic pop_rd;
        logic pop_restore;
        logic finish;
    } dgcc_cmd_t;

    typedef struct packed {
        logic overflow_now;
        logic clr_last;
        logic root_white;
        logic root_last;
        logic scan_more;
        logic edge_match;
        logic col_gray;
        logic col_white;
        logic depth_zero;
        logic out_busy;
    } dgcc_sts_t;
endpackage

[design/dgcc_ram.sv]
// generic single write, single read ram with registered read
// no dependencies
module dgcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

[design/dgcc_ctrl.sv]
// controller of the cycle check: load, colour clear, depth-first walk, result
// depends on dgcc_pkg
module dgcc_ctrl import dgcc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_last_edge,
    output logic      s_ready,
    input  dgcc_sts_t sts,
    output dgcc_cmd_t cmd
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_ROOT  = 4'd2;
    localparam logic [3:0] ST_ROOTW = 4'd3;
    localparam logic [3:0] ST_NEXT  = 4'd4;
    localparam logic [3:0] ST_SCAN  = 4'd5;
    localparam logic [3:0] ST_EDGE  = 4'd6;
    localparam logic [3:0] ST_COLOR = 4'd7;
    localparam logic [3:0] ST_POP   = 4'd8;
    localparam logic [3:0] ST_POPW  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last_edge) begin
                        if (sts.overflow_now) begin
                            state_next = ST_DONE;
                        end else begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_rd = 1'b1;
                state_next  = ST_ROOTW;
            end
            ST_ROOTW: begin
                if (sts.root_white) begin
                    cmd.root_take = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (sts.root_last) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.root_next = 1'b1;
                    state_next    = ST_ROOT;
                end
            end
            ST_SCAN: begin
                if (sts.scan_more) begin
                    cmd.scan_rd = 1'b1;
                    state_next  = ST_EDGE;
                end else begin
                    state_next = ST_POP;
                end
            end
            ST_EDGE: begin
                if (sts.edge_match) begin
                    cmd.col_rd = 1'b1;
                    state_next = ST_COLOR;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_COLOR: begin
                if (sts.col_gray) begin
                    cmd.fail   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cmd.push   = sts.col_white;
                    state_next = ST_SCAN;
                end
            end
            ST_POP: begin
                cmd.pop_black = 1'b1;
                if (sts.depth_zero) begin
                    state_next = ST_NEXT;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POPW;
                end
            end
            ST_POPW: begin
                cmd.pop_restore = 1'b1;
                state_next      = ST_SCAN;
            end
            ST_DONE: begin
                if (!sts.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

[design/dgcc_dp.sv]
// datapath of the cycle check: edge store, colour store, walk stack, result register
// depends on dgcc_pkg, dgcc_ram, assert_macros.svh
`include "assert_macros.svh"
module dgcc_dp import dgcc_pkg::*; #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_edge_present,
    input  logic [NODE_W-1:0] s_dependent_node,
    input  logic [NODE_W-1:0] s_prereq_node,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_acyclic,
    output logic              m_overflow,
    input  dgcc_cmd_t         cmd,
    output dgcc_sts_t         sts
);
    localparam int ND  = (MAX_NODES > (1 << NODE_W)) ? (1 << NODE_W) : MAX_NODES;
    localparam int NAW = $clog2(ND);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EDEPTH = 1 << EAW;
    localparam int SW  = NAW + ECW;

    logic [ECW-1:0] count_reg, next_reg;
    logic [NAW-1:0] n_reg, u_reg, depth_reg;
    logic           ov_reg, ok_reg;
    logic           m_valid_reg, m_acyclic_reg, m_overflow_reg;

    logic           bad_now;
    logic           e_wr;
    logic [2*NAW-1:0] e_wdata, e_rdata;
    logic [NAW-1:0] e_src, e_dst;

    logic           c_wr;
    logic [NAW-1:0] c_waddr, c_raddr;
    logic [1:0]     c_wdata, c_rdata;

    logic [SW-1:0]  k_rdata;

    assign bad_now = (count_reg == ECW'(MAX_EDGES))
                  || ({1'b0, s_dependent_node} >= (NODE_W+1)'(ND))
                  || ({1'b0, s_prereq_node} >= (NODE_W+1)'(ND));
    assign e_wr    = cmd.load && s_edge_present && !bad_now;
    assign e_wdata = {s_prereq_node[NAW-1:0], s_dependent_node[NAW-1:0]};
    assign e_src   = e_rdata[2*NAW-1:NAW];
    assign e_dst   = e_rdata[NAW-1:0];

    dgcc_ram #(.WIDTH(2*NAW), .DEPTH(EDEPTH)) u_edges (
        .aclk    (aclk),
        .wr_en   (e_wr),
        .wr_addr (count_reg[EAW-1:0]),
        .wr_data (e_wdata),
        .rd_en   (cmd.scan_rd),
        .rd_addr (next_reg[EAW-1:0]),
        .rd_data (e_rdata)
    );

    always_comb begin
        c_wr    = 1'b1;
        c_waddr = n_reg;
        c_wdata = CLR_WHITE;
        if (cmd.root_take) begin
            c_wdata = CLR_GRAY;
        end else if (cmd.push) begin
            c_waddr = e_dst;
            c_wdata = CLR_GRAY;
        end else if (cmd.pop_black) begin
            c_waddr = u_reg;
            c_wdata = CLR_BLACK;
        end else if (!cmd.clr_step) begin
            c_wr = 1'b0;
        end
    end
    assign c_raddr = cmd.col_rd ? e_dst : n_reg;

    dgcc_ram #(.WIDTH(2), .DEPTH(1 << NAW)) u_colours (
        .aclk    (aclk),
        .wr_en   (c_wr),
        .wr_addr (c_waddr),
        .wr_data (c_wdata),
        .rd_en   (cmd.root_rd || cmd.col_rd),
        .rd_addr (c_raddr),
        .rd_data (c_rdata)
    );

    dgcc_ram #(.WIDTH(SW), .DEPTH(1 << NAW)) u_stack (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (depth_reg),
        .wr_data ({u_reg, next_reg}),
        .rd_en   (cmd.pop_rd),
        .rd_addr (depth_reg - NAW'(1)),
        .rd_data (k_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ov_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (e_wr) begin
                count_reg <= count_reg + ECW'(1);
            end
            if (cmd.load && s_edge_present && bad_now) begin
                ov_reg <= 1'b1;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                count_reg   <= '0;
                ov_reg      <= 1'b0;
                m_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_acyclic_reg  <= ok_reg && !ov_reg;
            m_overflow_reg <= ov_reg;
        end
        if (cmd.clr_start) begin
            n_reg  <= '0;
            ok_reg <= 1'b1;
        end else if (cmd.clr_step) begin
            n_reg <= (n_reg == NAW'(ND - 1)) ? '0 : n_reg + NAW'(1);
        end else if (cmd.root_next) begin
            n_reg <= n_reg + NAW'(1);
        end
        if (cmd.fail) begin
            ok_reg <= 1'b0;
        end
        if (cmd.root_take) begin
            u_reg     <= n_reg;
            next_reg  <= '0;
            depth_reg <= '0;
        end else if (cmd.scan_rd) begin
            next_reg <= next_reg + ECW'(1);
        end else if (cmd.push) begin
            u_reg     <= e_dst;
            next_reg  <= '0;
            depth_reg <= depth_reg + NAW'(1);
        end else if (cmd.pop_rd) begin
            depth_reg <= depth_reg - NAW'(1);
        end else if (cmd.pop_restore) begin
            u_reg    <= k_rdata[SW-1:ECW];
            next_reg <= k_rdata[ECW-1:0];
        end
    end

    assign sts.overflow_now = ov_reg || (s_edge_present && bad_now);
    assign sts.clr_last     = (n_reg == NAW'(ND - 1));
    assign sts.root_white   = (c_rdata == CLR_WHITE);
    assign sts.root_last    = (n_reg == NAW'(ND - 1));
    assign sts.scan_more    = (next_reg < count_reg);
    assign sts.edge_match   = (e_src == u_reg);
    assign sts.col_gray     = (c_rdata == CLR_GRAY);
    assign sts.col_white    = (c_rdata == CLR_WHITE);
    assign sts.depth_zero   = (depth_reg == '0);
    assign sts.out_busy     = m_valid_reg;

    assign m_valid    = m_valid_reg;
    assign m_acyclic  = m_acyclic_reg;
    assign m_overflow = m_overflow_reg;

    `DGCC_NEVER(a_no_result_overrun, aclk, aresetn, cmd.finish && m_valid_reg, "result overwritten")
    `DGCC_NEVER(a_stack_bound, aclk, aresetn, cmd.push && (depth_reg == NAW'(ND - 1)), "stack overrun")
    `DGCC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= ECW'(MAX_EDGES), "edge count too big")
endmodule

[design/directed_graph_cycle_check.sv]
// top level of the directed graph cycle check
// depends on dgcc_pkg, dgcc_ctrl, dgcc_dp
// Edges are taken one per cycle while s_ready is high (only in the idle state) and stored;
// the request that carries s_last_edge starts, unless an overflow was seen, a colour clear
// of MAX_NODES nodes (at most 256) followed by a depth-first walk in which every stored edge
// is read once per node visited. Each edge read goes through a scan state that reads it, an
// edge state that checks whether it leaves the current node and, if so, a colour state that
// reads its destination; only one edge read is in flight at a time. Edges of the next set are
// taken while the previous result waits on the m_ side.
module directed_graph_cycle_check import dgcc_pkg::*; #(
    parameter int MAX_NODES = 256,
    parameter int MAX_EDGES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_edge_present,
    input  logic [NODE_W-1:0] s_dependent_node,
    input  logic [NODE_W-1:0] s_prereq_node,
    input  logic              s_last_edge,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_acyclic,
    output logic              m_overflow
);
    dgcc_cmd_t cmd;
    dgcc_sts_t sts;

    dgcc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_last_edge (s_last_edge),
        .s_ready     (s_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    dgcc_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_edge_present   (s_edge_present),
        .s_dependent_node (s_dependent_node),
        .s_prereq_node    (s_prereq_node),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_acyclic        (m_acyclic),
        .m_overflow       (m_overflow),
        .cmd              (cmd),
        .sts              (sts)
    );
endmodule
